/* hw/rtl/dmm_pkg.sv */
`timescale 1ns / 1ps
// Package for the depth min/max normalizer: widths, command codes and the
// control struct handed along the divider chain. Depends on nothing.
package dmm_pkg;

    localparam int SAMPLE_BITS_DEF = 32;
    localparam int DEPTH_BITS      = 32;
    localparam int GRAY_BITS       = 8;
    localparam int QUOT_STEPS      = GRAY_BITS;
    localparam logic [GRAY_BITS-1:0] GRAY_FULL = 8'd255;

    typedef enum logic {
        CMD_SCAN    = 1'b0,
        CMD_CONVERT = 1'b1
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic last;
        logic zero;
        logic full;
    } t_ctl;

endpackage

/* hw/rtl/dmm_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for depth items in and gray items out.
// Depends on dmm_pkg.
interface dmm_in_if import dmm_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [0:0]                   cmd;
    logic signed [DEPTH_BITS-1:0] depth;
    logic                         last;

    modport source (output valid, cmd, depth, last, input ready);
    modport sink   (input valid, cmd, depth, last, output ready);
endinterface

interface dmm_out_if import dmm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [GRAY_BITS-1:0] gray;
    logic                 gray_last;

    modport source (output valid, gray, gray_last, input ready);
    modport sink   (input valid, gray, gray_last, output ready);
endinterface

/* hw/rtl/depth_minmax_normalize_to_gray8.sv */
`timescale 1ns / 1ps
// Top level of the depth min/max normalizer: front end, a chain of division
// cells and the output register. Depends on dmm_pkg, dmm_if, dmm_front, dmm_div_cell.
//
//   Channel  Dir  Payload               Item carries
//   i_in     in   cmd, depth, last      one depth sample of a scan or convert pass
//   o_out    out  gray, gray_last       one gray value per convert sample
//
// An item is taken in every cycle in which the output register is empty or being read.
// A convert item passes the first front stage, which loads at the edge that accepts it,
// then the second front stage, one cell each, and the output register.
// A stalled output freezes the whole chain and holds ready low.
// Reset is synchronous and needs no clearing pass; it restores the empty min/max.
module depth_minmax_normalize_to_gray8 import dmm_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    dmm_in_if.sink           i_in,
    dmm_out_if.source        o_out
);

    localparam int W = SAMPLE_BITS;

    logic                 w_en, w_accept;
    t_ctl                 w_ctl  [0:QUOT_STEPS];
    logic [W:0]           w_rem  [0:QUOT_STEPS];
    logic [W:0]           w_rng  [0:QUOT_STEPS];
    logic [GRAY_BITS-1:0] w_low  [0:QUOT_STEPS];
    logic [GRAY_BITS-1:0] w_quot [0:QUOT_STEPS];

    logic                 r_out_valid, r_out_last;
    logic [GRAY_BITS-1:0] r_out_gray;
    logic [GRAY_BITS-1:0] w_gray;

    assign w_en       = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && w_en;
    assign i_in.ready = w_en;

    dmm_front #(.SAMPLE_BITS(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_accept(w_accept),
        .i_cmd   (i_in.cmd),
        .i_depth (i_in.depth[W-1:0]),
        .i_last  (i_in.last),
        .o_ctl   (w_ctl[0]),
        .o_rem   (w_rem[0]),
        .o_low   (w_low[0]),
        .o_range (w_rng[0])
    );

    assign w_quot[0] = '0;

    for (genvar g = 0; g < QUOT_STEPS; g++) begin : g_cell
        dmm_div_cell #(.SAMPLE_BITS(W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[g]),
            .i_rem   (w_rem[g]),
            .i_low   (w_low[g]),
            .i_quot  (w_quot[g]),
            .i_range (w_rng[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_low   (w_low[g+1]),
            .o_quot  (w_quot[g+1]),
            .o_range (w_rng[g+1])
        );
    end

    always_comb begin
        priority if (w_ctl[QUOT_STEPS].zero) begin
            w_gray = '0;
        end else if (w_ctl[QUOT_STEPS].full) begin
            w_gray = GRAY_FULL;
        end else begin
            w_gray = w_quot[QUOT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_ctl[QUOT_STEPS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_gray <= w_gray;
            r_out_last <= w_ctl[QUOT_STEPS].last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.gray      = r_out_gray;
    assign o_out.gray_last = r_out_last;

endmodule

/* hw/rtl/dmm_front.sv */
`timescale 1ns / 1ps
// Front end: running minimum and maximum of the scan pass, and two stages that
// form the offset, the range and the scaled dividend. Depends on dmm_pkg.
module dmm_front import dmm_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_accept,
    input  logic [0:0]             i_cmd,
    input  logic [SAMPLE_BITS-1:0] i_depth,
    input  logic                   i_last,
    output t_ctl                   o_ctl,
    output logic [SAMPLE_BITS:0]   o_rem,
    output logic [GRAY_BITS-1:0]   o_low,
    output logic [SAMPLE_BITS:0]   o_range
);

    localparam int W = SAMPLE_BITS;
    localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0] r_min, r_max;
    logic                r_fresh;
    logic signed [W-1:0] w_d, w_base_min, w_base_max;
    logic                w_scan, w_conv;

    t_ctl                r_a_ctl;
    logic signed [W:0]   r_a_num, r_a_range;

    t_ctl                r_b_ctl;
    logic [W:0]          r_b_rem, r_b_range;
    logic [GRAY_BITS-1:0] r_b_low;
    t_ctl                n_b_ctl;
    logic [W+GRAY_BITS:0] w_prod;

    assign w_d        = ($signed(i_depth) == SMIN) ? '0 : $signed(i_depth);
    assign w_base_min = r_fresh ? SMAX : r_min;
    assign w_base_max = r_fresh ? SMIN : r_max;
    assign w_scan     = i_accept && (t_cmd'(i_cmd) == CMD_SCAN);
    assign w_conv     = i_accept && (t_cmd'(i_cmd) == CMD_CONVERT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= SMAX;
            r_max   <= SMIN;
            r_fresh <= 1'b1;
        end else if (w_scan) begin
            r_min   <= (w_d < w_base_min) ? w_d : w_base_min;
            r_max   <= (w_d > w_base_max) ? w_d : w_base_max;
            r_fresh <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else if (i_en) begin
            r_a_ctl <= '{valid: w_conv, last: i_last, zero: 1'b0, full: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_num   <= {w_d[W-1], w_d} - {r_min[W-1], r_min};
            r_a_range <= {r_max[W-1], r_max} - {r_min[W-1], r_min};
        end
    end

    assign w_prod = {r_a_num, {GRAY_BITS{1'b0}}} - {{GRAY_BITS{r_a_num[W]}}, r_a_num};

    always_comb begin
        n_b_ctl       = r_a_ctl;
        n_b_ctl.zero  = (r_a_range <= 0) || (r_a_num <= 0);
        n_b_ctl.full  = (r_a_num >= r_a_range);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
        end else if (i_en) begin
            r_b_ctl <= n_b_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_rem   <= w_prod[W+GRAY_BITS:GRAY_BITS];
            r_b_low   <= w_prod[GRAY_BITS-1:0];
            r_b_range <= r_a_range;
        end
    end

    assign o_ctl   = r_b_ctl;
    assign o_rem   = r_b_rem;
    assign o_low   = r_b_low;
    assign o_range = r_b_range;

endmodule

/* hw/rtl/dmm_div_cell.sv */
`timescale 1ns / 1ps
// One restoring division cell: shifts in a dividend bit, compares with the
// range and yields one quotient bit per item. Depends on dmm_pkg.
module dmm_div_cell import dmm_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  t_ctl                   i_ctl,
    input  logic [SAMPLE_BITS:0]   i_rem,
    input  logic [GRAY_BITS-1:0]   i_low,
    input  logic [GRAY_BITS-1:0]   i_quot,
    input  logic [SAMPLE_BITS:0]   i_range,
    output t_ctl                   o_ctl,
    output logic [SAMPLE_BITS:0]   o_rem,
    output logic [GRAY_BITS-1:0]   o_low,
    output logic [GRAY_BITS-1:0]   o_quot,
    output logic [SAMPLE_BITS:0]   o_range
);

    localparam int W = SAMPLE_BITS;

    t_ctl                 r_ctl;
    logic [W:0]           r_rem, r_range;
    logic [GRAY_BITS-1:0] r_low, r_quot;
    logic [W+1:0]         w_trial, w_diff;
    logic                 w_ge;

    assign w_trial = {i_rem, i_low[GRAY_BITS-1]};
    assign w_diff  = w_trial - {1'b0, i_range};
    assign w_ge    = (w_trial >= {1'b0, i_range});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem   <= w_ge ? w_diff[W:0] : w_trial[W:0];
            r_low   <= {i_low[GRAY_BITS-2:0], 1'b0};
            r_quot  <= {i_quot[GRAY_BITS-2:0], w_ge};
            r_range <= i_range;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_rem   = r_rem;
    assign o_low   = r_low;
    assign o_quot  = r_quot;
    assign o_range = r_range;

endmodule

/* hw/rtl/dmm_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the depth normalizer and the bind that attaches them.
// Depends on dmm_pkg and the top level depth_minmax_normalize_to_gray8.
module dmm_checker import dmm_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [GRAY_BITS-1:0] i_out_gray,
    input logic                 i_out_last
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid directly after reset");

    a_no_early_result: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_out_valid ##1 !i_out_valid ##1 !i_out_valid)
        else $error("result appeared before any item could pass the chain");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled although the output is free");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_gray) && $stable(i_out_last)))
        else $error("stalled output item changed");

endmodule

bind depth_minmax_normalize_to_gray8 dmm_checker u_dmm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_gray  (o_out.gray),
    .i_out_last  (o_out.gray_last)
);
